[hdl/sfla_pkg.sv]
`default_nettype none
package sfla_pkg;

  // Arena geometry
  localparam int unsigned ARENA_BYTES = 65536;
  localparam int unsigned ADDR_W      = 17;
  localparam int unsigned LINK_AW     = 13;
  localparam int unsigned LINK_DEPTH  = 8192;
  localparam int unsigned NUM_LISTS   = 16;
  localparam int unsigned CLS_W       = 4;
  localparam logic [ADDR_W-1:0] NIL_ADDR = 17'h10000;
  localparam logic [15:0] SMALL_LIMIT = 16'd128;

  // Refill count register
  localparam logic [5:0] REFILL_RESET = 6'd20;
  localparam logic [5:0] REFILL_MAX   = 6'd32;

  // Commands; the last code is unused and answered with an empty result.
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_LARGE      = 2'd1;
  localparam logic [1:0] STAT_OOM        = 2'd2;
  localparam logic [1:0] STAT_LARGE_FREE = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] size;
    logic [15:0] old_size;
    logic [15:0] block_address;
  } in_word_t;

  typedef struct packed {
    logic [15:0] address;
    logic [1:0]  status;
  } out_word_t;

  // Request from the sequencer to the link word memory
  typedef struct packed {
    logic               we;
    logic [LINK_AW-1:0] waddr;
    logic [ADDR_W-1:0]  wdata;
    logic [LINK_AW-1:0] raddr;
  } link_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FREE, S_ALLOC, S_HIT, S_CHUNK, S_DIV, S_THREAD, S_SEARCH, S_SRD, S_DONE
  } state_t;

endpackage
`default_nettype wire

[hdl/segregated_free_list_allocator.sv]
// Small-block allocator over a 64 KiB arena with sixteen 8-byte size classes.
// Input channel in_valid / in_data / in_stall: a word is taken when in_valid
// is high and in_stall is low. Each word is an allocate, free or reallocate.
// Result channel out_valid / out_data / out_stall: one result word for each
// input word, taken when out_valid is high and out_stall is low.
// Configuration channel cfg_valid / cfg_data / cfg_ready writes refill_count;
// it is ready only while the block is idle.
// The block works on one word at a time and takes no word while busy. A free
// is answered from the free step; an allocate from a non-empty list reads the
// head, then the successor link. A refill threads one link word per carved
// block (up to 32), grows the pool from the arena when the pool is spent, and
// first counts the blocks that fit when the pool is short. When the arena is
// spent the larger classes are scanned at one class a cycle. The pace is set
// by the sequencer's single link memory port and its adder.
// Reset (synchronous, rst_n low) empties all lists and the pool and sets
// refill_count to 20. When the receiver stalls, the result waits in the
// output register; the block may take and work out one more word, then holds
// in_stall high until the output register empties.
`default_nettype none
module segregated_free_list_allocator (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire sfla_pkg::in_word_t  in_data,
  output logic                     in_stall,
  output logic                     out_valid,
  output sfla_pkg::out_word_t      out_data,
  input  wire logic                out_stall,
  input  wire logic                cfg_valid,
  input  wire logic [5:0]          cfg_data,
  output logic                     cfg_ready
);

  logic                        cfg_write;
  logic [5:0]                  refill_count_r;
  logic                        in_ready;
  logic                        res_valid;
  sfla_pkg::out_word_t         res_data;
  logic                        res_take;
  sfla_pkg::link_req_t         link_req;
  logic [sfla_pkg::ADDR_W-1:0] link_rdata;
  logic                        out_valid_r;
  sfla_pkg::out_word_t         out_data_r;

  assign in_stall  = !in_ready;
  assign cfg_ready = in_ready && !res_valid;
  assign res_take  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_write = cfg_valid && cfg_ready;

  // Refill count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refill_count_r <= sfla_pkg::REFILL_RESET;
    end else if (cfg_write) begin
      refill_count_r <= cfg_data;
    end
  end

  // Output register between the sequencer and the receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data_r <= res_data;
    end
  end

  sfla_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .in_ready     (in_ready),
    .refill_count (refill_count_r),
    .res_valid    (res_valid),
    .res_data     (res_data),
    .res_take     (res_take),
    .link_req     (link_req),
    .link_rdata   (link_rdata)
  );

  sfla_link_ram u_link_ram (
    .clk   (clk),
    .req   (link_req),
    .rdata (link_rdata)
  );

endmodule
`default_nettype wire

[hdl/sfla_link_ram.sv]
`default_nettype none
module sfla_link_ram (
  input  wire logic               clk,
  input  wire sfla_pkg::link_req_t req,
  output logic [sfla_pkg::ADDR_W-1:0] rdata
);

  logic [sfla_pkg::ADDR_W-1:0] mem [sfla_pkg::LINK_DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

[hdl/sfla_ctrl.sv]
`default_nettype none
module sfla_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire sfla_pkg::in_word_t   in_data,
  output logic                      in_ready,
  input  wire logic [5:0]           refill_count,
  output logic                      res_valid,
  output sfla_pkg::out_word_t       res_data,
  input  wire logic                 res_take,
  output sfla_pkg::link_req_t       link_req,
  input  wire logic [sfla_pkg::ADDR_W-1:0] link_rdata
);

  localparam int unsigned AW = sfla_pkg::ADDR_W;
  localparam int unsigned CW = sfla_pkg::CLS_W;

  sfla_pkg::state_t state_r, state_nxt;
  sfla_pkg::in_word_t word_r, word_nxt;

  logic [AW-1:0] heads_r [sfla_pkg::NUM_LISTS];
  logic [CW-1:0] cls_r, cls_nxt;
  logic [5:0]    nobjs_r, nobjs_nxt;
  logic [AW-1:0] pool_start_r, pool_start_nxt;
  logic [AW-1:0] pool_end_r, pool_end_nxt;
  logic [AW-1:0] heap_r, heap_nxt;
  logic [AW-1:0] arena_r, arena_nxt;
  logic [13:0]   acc_r, acc_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [5:0]    k_r, k_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [AW-1:0] chunk_r, chunk_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  sfla_pkg::out_word_t res_r, res_nxt;

  // Head table: one read index and one write port per cycle
  logic [CW-1:0] hidx;
  logic [AW-1:0] head_rd;
  logic          hw_en;
  logic [CW-1:0] hw_idx;
  logic [AW-1:0] hw_data;

  // Shared arithmetic
  logic          size_small, old_small;
  logic [15:0]   size_m1, old_m1;
  logic [CW-1:0] size_cls, old_cls;
  logic [7:0]    bytes, old_bytes;
  logic [13:0]   need;
  logic [AW-1:0] left, left_m1;
  logic [AW-1:0] aligned;
  logic [AW-1:0] free_end;
  logic [13:0]   h4p;
  logic [17:0]   get, room;
  logic          fits;
  logic [5:0]    refill_clamped;
  logic [13:0]   acc_step;
  logic [AW-1:0] scan_bytes;

  assign size_small = word_r.size <= sfla_pkg::SMALL_LIMIT;
  assign old_small  = word_r.old_size <= sfla_pkg::SMALL_LIMIT;
  assign size_m1    = word_r.size - 16'd1;
  assign old_m1     = word_r.old_size - 16'd1;
  assign size_cls   = (word_r.size == 16'd0) ? '0 : size_m1[6:3];
  assign old_cls    = (word_r.old_size == 16'd0) ? '0 : old_m1[6:3];
  assign bytes      = {5'({1'b0, cls_r}) + 5'd1, 3'b000};
  assign old_bytes  = {5'({1'b0, old_cls}) + 5'd1, 3'b000};
  assign need       = {6'd0, bytes} * {8'd0, nobjs_r};
  assign left       = pool_end_r - pool_start_r;
  assign left_m1    = left - 17'd1;
  assign aligned    = {1'b0, word_r.block_address[15:3], 3'b000};
  assign free_end   = aligned + {9'd0, old_bytes};
  assign h4p        = {1'b0, heap_r[16:4]} + 14'd7;
  assign get        = {3'd0, need, 1'b0} + {4'd0, h4p[13:3], 3'd0};
  assign room       = 18'h10000 - {1'b0, arena_r};
  assign fits       = get <= room;
  assign acc_step   = acc_r + {6'd0, bytes};
  assign scan_bytes = {9'd0, 5'({1'b0, scan_r}) + 5'd1, 3'b000};

  always_comb begin
    if (refill_count == 6'd0) begin
      refill_clamped = 6'd1;
    end else if (refill_count > sfla_pkg::REFILL_MAX) begin
      refill_clamped = sfla_pkg::REFILL_MAX;
    end else begin
      refill_clamped = refill_count;
    end
  end

  assign head_rd   = heads_r[hidx];
  assign in_ready  = state_r == sfla_pkg::S_IDLE;
  assign res_valid = state_r == sfla_pkg::S_DONE;
  assign res_data  = res_r;

  // Sequencer: next state, datapath updates and memory requests.
  always_comb begin
    state_nxt      = state_r;
    word_nxt       = word_r;
    cls_nxt        = cls_r;
    nobjs_nxt      = nobjs_r;
    pool_start_nxt = pool_start_r;
    pool_end_nxt   = pool_end_r;
    heap_nxt       = heap_r;
    arena_nxt      = arena_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    scan_nxt       = scan_r;
    chunk_nxt      = chunk_r;
    cur_nxt        = cur_r;
    res_nxt        = res_r;
    hidx           = cls_r;
    hw_en          = 1'b0;
    hw_idx         = cls_r;
    hw_data        = head_rd;
    link_req.we    = 1'b0;
    link_req.waddr = cur_r[15:3];
    link_req.wdata = head_rd;
    link_req.raddr = head_rd[15:3];

    case (state_r)
      sfla_pkg::S_IDLE: begin
        if (in_valid) begin
          word_nxt = in_data;
          if (in_data.command == sfla_pkg::CMD_FREE ||
              in_data.command == sfla_pkg::CMD_REALLOC) begin
            state_nxt = sfla_pkg::S_FREE;
          end else if (in_data.command == sfla_pkg::CMD_ALLOC) begin
            state_nxt = sfla_pkg::S_ALLOC;
          end else begin
            res_nxt   = '{address: 16'd0, status: sfla_pkg::STAT_OK};
            state_nxt = sfla_pkg::S_DONE;
          end
        end
      end

      // Push the freed block onto its list if it is small and lies inside the arena.
      sfla_pkg::S_FREE: begin
        hidx = old_cls;
        if (old_small && free_end <= 17'h10000) begin
          hw_en          = 1'b1;
          hw_idx         = old_cls;
          hw_data        = aligned;
          link_req.we    = 1'b1;
          link_req.waddr = aligned[15:3];
          link_req.wdata = head_rd;
        end
        if (word_r.command == sfla_pkg::CMD_FREE) begin
          res_nxt   = '{address: 16'd0,
                        status: old_small ? sfla_pkg::STAT_OK : sfla_pkg::STAT_LARGE_FREE};
          state_nxt = sfla_pkg::S_DONE;
        end else begin
          state_nxt = sfla_pkg::S_ALLOC;
        end
      end

      sfla_pkg::S_ALLOC: begin
        hidx    = size_cls;
        cls_nxt = size_cls;
        if (!size_small) begin
          res_nxt   = '{address: 16'd0, status: sfla_pkg::STAT_LARGE};
          state_nxt = sfla_pkg::S_DONE;
        end else if (head_rd != sfla_pkg::NIL_ADDR) begin
          link_req.raddr = head_rd[15:3];
          res_nxt        = '{address: head_rd[15:0], status: sfla_pkg::STAT_OK};
          state_nxt      = sfla_pkg::S_HIT;
        end else begin
          nobjs_nxt = refill_clamped;
          state_nxt = sfla_pkg::S_CHUNK;
        end
      end

      // Pop: the successor link has arrived from the memory.
      sfla_pkg::S_HIT: begin
        hw_en     = 1'b1;
        hw_idx    = cls_r;
        hw_data   = link_rdata;
        state_nxt = sfla_pkg::S_DONE;
      end

      sfla_pkg::S_CHUNK: begin
        hidx = left_m1[6:3];
        if (left >= {3'd0, need}) begin
          chunk_nxt      = pool_start_r;
          pool_start_nxt = pool_start_r + {3'd0, need};
          cur_nxt        = pool_start_r + {9'd0, bytes};
          k_nxt          = 6'd1;
          state_nxt      = sfla_pkg::S_THREAD;
        end else if (left >= {9'd0, bytes}) begin
          acc_nxt   = {6'd0, bytes};
          cnt_nxt   = 6'd1;
          state_nxt = sfla_pkg::S_DIV;
        end else begin
          // Remainder of the pool goes onto its own list.
          if (left != '0) begin
            hw_en          = 1'b1;
            hw_idx         = left_m1[6:3];
            hw_data        = pool_start_r;
            link_req.we    = 1'b1;
            link_req.waddr = pool_start_r[15:3];
            link_req.wdata = head_rd;
          end
          if (fits) begin
            pool_start_nxt = arena_r;
            pool_end_nxt   = arena_r + get[AW-1:0];
            arena_nxt      = arena_r + get[AW-1:0];
            heap_nxt       = heap_r + get[AW-1:0];
          end else begin
            pool_start_nxt = pool_end_r;
            scan_nxt       = cls_r;
            state_nxt      = sfla_pkg::S_SEARCH;
          end
        end
      end

      // How many blocks fit in the short pool, one addition step a cycle.
      sfla_pkg::S_DIV: begin
        if ({3'd0, acc_step} <= left) begin
          acc_nxt = acc_step;
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          nobjs_nxt      = cnt_r;
          chunk_nxt      = pool_start_r;
          pool_start_nxt = pool_start_r + {3'd0, acc_r};
          cur_nxt        = pool_start_r + {9'd0, bytes};
          k_nxt          = 6'd1;
          state_nxt      = sfla_pkg::S_THREAD;
        end
      end

      // Thread the carved blocks, one link word per cycle.
      sfla_pkg::S_THREAD: begin
        if (k_r < nobjs_r) begin
          link_req.we    = 1'b1;
          link_req.waddr = cur_r[15:3];
          link_req.wdata = (k_r + 6'd1 == nobjs_r) ? sfla_pkg::NIL_ADDR
                                                   : cur_r + {9'd0, bytes};
          k_nxt   = k_r + 6'd1;
          cur_nxt = cur_r + {9'd0, bytes};
        end else begin
          if (nobjs_r > 6'd1) begin
            hw_en   = 1'b1;
            hw_idx  = cls_r;
            hw_data = chunk_r + {9'd0, bytes};
          end
          res_nxt   = '{address: chunk_r[15:0], status: sfla_pkg::STAT_OK};
          state_nxt = sfla_pkg::S_DONE;
        end
      end

      // Look through this and larger classes for a block to become the pool.
      sfla_pkg::S_SEARCH: begin
        hidx = scan_r;
        if (head_rd != sfla_pkg::NIL_ADDR) begin
          link_req.raddr = head_rd[15:3];
          cur_nxt        = head_rd;
          state_nxt      = sfla_pkg::S_SRD;
        end else if (scan_r == CW'(sfla_pkg::NUM_LISTS - 1)) begin
          pool_start_nxt = '0;
          pool_end_nxt   = '0;
          res_nxt        = '{address: 16'd0, status: sfla_pkg::STAT_OOM};
          state_nxt      = sfla_pkg::S_DONE;
        end else begin
          scan_nxt = scan_r + CW'(1);
        end
      end

      sfla_pkg::S_SRD: begin
        hw_en          = 1'b1;
        hw_idx         = scan_r;
        hw_data        = link_rdata;
        pool_start_nxt = cur_r;
        pool_end_nxt   = cur_r + scan_bytes;
        state_nxt      = sfla_pkg::S_CHUNK;
      end

      sfla_pkg::S_DONE: begin
        if (res_take) begin
          state_nxt = sfla_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = sfla_pkg::S_IDLE;
      end
    endcase
  end

  // State register and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sfla_pkg::S_IDLE;
      pool_start_r <= '0;
      pool_end_r   <= '0;
      heap_r       <= '0;
      arena_r      <= '0;
      for (int i = 0; i < int'(sfla_pkg::NUM_LISTS); i++) begin
        heads_r[i] <= sfla_pkg::NIL_ADDR;
      end
    end else begin
      state_r      <= state_nxt;
      pool_start_r <= pool_start_nxt;
      pool_end_r   <= pool_end_nxt;
      heap_r       <= heap_nxt;
      arena_r      <= arena_nxt;
      if (hw_en) begin
        heads_r[hw_idx] <= hw_data;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    cls_r   <= cls_nxt;
    nobjs_r <= nobjs_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
    k_r     <= k_nxt;
    scan_r  <= scan_nxt;
    chunk_r <= chunk_nxt;
    cur_r   <= cur_nxt;
    res_r   <= res_nxt;
  end

  // The pool never runs backwards.
  a_pool_order: assert property (@(posedge clk) disable iff (!rst_n)
    pool_end_r >= pool_start_r) else $error("pool end below pool start");

  // Everything taken from the arena is counted in the heap total.
  a_heap_arena: assert property (@(posedge clk) disable iff (!rst_n)
    heap_r == arena_r) else $error("heap total and arena pointer disagree");

  // The arena pointer stays inside the arena.
  a_arena_bound: assert property (@(posedge clk) disable iff (!rst_n)
    arena_r <= 17'h10000) else $error("arena pointer past the arena");

  // After a word is taken the block is busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_valid) |=> !in_ready) else $error("ready while busy");

endmodule
`default_nettype wire
